/* sv/mavlink2_frame_builder_top_assert.svh */
// Assertion macros shared by the frame builder modules.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef MAVLINK2_FRAME_BUILDER_TOP_ASSERT_SVH
`define MAVLINK2_FRAME_BUILDER_TOP_ASSERT_SVH

// The condition must hold at every clock edge.
`define MV2FB_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("frame builder invariant violated");

// When the antecedent holds, the consequent must hold in the following cycle.
`define MV2FB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame builder sequence violated");

`endif

/* sv/mv2fb_pkg.sv */
package mv2fb_pkg;

    // Input mode codes.
    localparam logic [1:0] MODE_HDR = 2'd0;
    localparam logic [1:0] MODE_PAY = 2'd1;
    localparam logic [1:0] MODE_END = 2'd2;

    localparam logic [7:0]  STX_BYTE    = 8'hFD;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [7:0]  MAX_PAYLOAD = 8'hFF;

    // Step counter inside one command; a header takes ten output bytes.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] HDR_LAST_STEP = 4'd9;

    // Default depth of the command queue between front and back.
    localparam int CMD_QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        CMD_HDR,
        CMD_PAY,
        CMD_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [23:0] message_id;
        logic [7:0]  declared_length;
        logic [7:0]  seq;
        logic [7:0]  system_id;
        logic [7:0]  component_id;
        logic [7:0]  data;
    } cmd_t;

    // One byte of CRC-16/X.25 (reflected, polynomial 0x1021).
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'h0};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b0, t, 3'b0} ^ {12'h000, t[7:4]};
    endfunction

endpackage

/* sv/mv2fb_front.sv */
module mv2fb_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        mode,
    input  logic [23:0]       message_id,
    input  logic [7:0]        declared_length,
    input  logic [7:0]        system_id,
    input  logic [7:0]        component_id,
    input  logic [7:0]        payload_byte,
    input  logic [7:0]        crc_seed_extra,
    input  logic              q_full,
    output logic              q_push,
    output mv2fb_pkg::cmd_t   q_data
);
    import mv2fb_pkg::*;

    logic       open_reg, open_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] seq_reg, seq_next;
    logic       accept;
    logic       take_hdr, take_pay, take_end;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Items that arrive out of order are consumed without producing a command.
    assign take_hdr = (mode == MODE_HDR) && !open_reg;
    assign take_pay = (mode == MODE_PAY) && open_reg && (count_reg != MAX_PAYLOAD);
    assign take_end = (mode == MODE_END) && open_reg;

    always_comb
    begin
        open_next  = open_reg;
        count_next = count_reg;
        seq_next   = seq_reg;
        q_push     = 1'b0;

        q_data.kind            = CMD_PAY;
        q_data.message_id      = message_id;
        q_data.declared_length = declared_length;
        q_data.seq             = seq_reg;
        q_data.system_id       = system_id;
        q_data.component_id    = component_id;
        q_data.data            = payload_byte;

        if (take_hdr)
        begin
            q_data.kind = CMD_HDR;
        end
        else if (take_end)
        begin
            q_data.kind = CMD_END;
            q_data.data = crc_seed_extra;
        end

        if (accept)
        begin
            if (take_hdr)
            begin
                q_push     = 1'b1;
                open_next  = 1'b1;
                count_next = 8'd0;
                seq_next   = seq_reg + 8'd1;
            end
            else if (take_pay)
            begin
                q_push     = 1'b1;
                count_next = count_reg + 8'd1;
            end
            else if (take_end)
            begin
                q_push     = 1'b1;
                open_next  = 1'b0;
                count_next = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            count_reg <= 8'd0;
            seq_reg   <= 8'd0;
        end
        else
        begin
            open_reg  <= open_next;
            count_reg <= count_next;
            seq_reg   <= seq_next;
        end
    end

endmodule

/* sv/mv2fb_fifo.sv */
`include "mavlink2_frame_builder_top_assert.svh"

module mv2fb_fifo #(
    parameter int DEPTH = mv2fb_pkg::CMD_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mv2fb_pkg::cmd_t   push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output mv2fb_pkg::cmd_t   head
);
    import mv2fb_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `MV2FB_ASSERT_ALWAYS(a_fifo_count_max, count_reg <= CNT_W'(DEPTH))
    `MV2FB_ASSERT_ALWAYS(a_fifo_no_lost_push, !push || !full)

endmodule

/* sv/mv2fb_back.sv */
`include "mavlink2_frame_builder_top_assert.svh"

module mv2fb_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  mv2fb_pkg::cmd_t   head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              frame_last
);
    import mv2fb_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic [15:0]       crc_reg, crc_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              frame_last_reg, frame_last_next;
    logic              can_emit, emit;
    logic [7:0]        byte_sel;
    logic              last_sel;
    logic              cmd_done;
    logic [15:0]       crc_sel;
    logic [15:0]       crc_end;

    assign can_emit = !out_valid_reg || out_ready;
    assign emit     = head_valid && can_emit;
    assign crc_end  = crc_fold(crc_reg, head.data);

    always_comb
    begin
        byte_sel = 8'h00;
        last_sel = 1'b0;
        cmd_done = 1'b0;
        crc_sel  = crc_reg;
        case (head.kind)
            CMD_HDR:
            begin
                case (step_reg)
                    4'd0:    byte_sel = STX_BYTE;
                    4'd1:    byte_sel = head.declared_length;
                    4'd4:    byte_sel = head.seq;
                    4'd5:    byte_sel = head.system_id;
                    4'd6:    byte_sel = head.component_id;
                    4'd7:    byte_sel = head.message_id[7:0];
                    4'd8:    byte_sel = head.message_id[15:8];
                    4'd9:    byte_sel = head.message_id[23:16];
                    default: byte_sel = 8'h00;
                endcase
                crc_sel  = (step_reg == '0) ? CRC_INIT : crc_fold(crc_reg, byte_sel);
                cmd_done = (step_reg == HDR_LAST_STEP);
            end
            CMD_PAY:
            begin
                byte_sel = head.data;
                crc_sel  = crc_fold(crc_reg, head.data);
                cmd_done = 1'b1;
            end
            CMD_END:
            begin
                if (step_reg == '0)
                begin
                    byte_sel = crc_end[7:0];
                    crc_sel  = crc_end;
                end
                else
                begin
                    byte_sel = crc_reg[15:8];
                    last_sel = 1'b1;
                    crc_sel  = CRC_INIT;
                    cmd_done = 1'b1;
                end
            end
            default:
            begin
                cmd_done = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        step_next       = step_reg;
        crc_next        = crc_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        frame_last_next = frame_last_reg;
        pop             = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = byte_sel;
            frame_last_next = last_sel;
            crc_next        = crc_sel;
            if (cmd_done)
            begin
                pop       = 1'b1;
                step_next = '0;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg   <= out_byte_next;
        frame_last_reg <= frame_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign frame_last = frame_last_reg;

    `MV2FB_ASSERT_ALWAYS(a_back_step_needs_head, (step_reg == '0) || head_valid)
    `MV2FB_ASSERT_NEXT(a_back_crc_reinit, emit && last_sel, crc_reg == CRC_INIT)

endmodule

/* sv/mavlink2_frame_builder_top.sv */
// An accepted item is written into the command queue, and the back registers its first output
// byte once the item is at the queue head. Throughput: one payload byte per cycle while the
// output is not stalled; a header item yields ten output bytes and an end item two.
// The command queue between front and back absorbs input while a header or CRC burst drains.
// Reset (rst_n low, asynchronous) closes any open frame, clears the sequence number and
// payload count, sets the CRC to 0xFFFF and empties the queue and output register.
module mavlink2_frame_builder_top #(
    parameter int CMD_DEPTH = mv2fb_pkg::CMD_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [23:0] message_id,
    input  logic [7:0]  declared_length,
    input  logic [7:0]  system_id,
    input  logic [7:0]  component_id,
    input  logic [7:0]  payload_byte,
    input  logic [7:0]  crc_seed_extra,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        frame_last
);
    import mv2fb_pkg::*;

    // Commands travel from the front (classification and frame bookkeeping)
    // through a short queue to the back (byte serialization and CRC).
    cmd_t q_push_data;
    cmd_t q_head;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_head_valid;

    // The front tracks whether a frame is open, counts payload bytes and
    // owns the sequence counter. Out-of-order transactions are accepted
    // and dropped here, so the back only ever sees well-formed frames.
    mv2fb_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .message_id      (message_id),
        .declared_length (declared_length),
        .system_id       (system_id),
        .component_id    (component_id),
        .payload_byte    (payload_byte),
        .crc_seed_extra  (crc_seed_extra),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_data          (q_push_data)
    );

    // The queue lets input continue while the back is stalled by the
    // output side or busy emitting a multi-byte burst.
    mv2fb_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    // The back emits one byte per cycle into its output register unless stalled, folding
    // header bytes after the start marker, payload bytes and crc_seed_extra into the running CRC.
    mv2fb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .frame_last (frame_last)
    );

endmodule

/* tb/sv/tb.sv */
module tb;

    import mv2fb_pkg::*;

    // The package names only the three working modes. The fourth code is
    // unused by the block and must be swallowed without output.
    localparam logic [1:0] MODE_NONE = 2'd3;

    // One input transaction, as it appears on the input ports.
    typedef struct packed {
        logic [1:0]  mode;
        logic [23:0] mid;
        logic [7:0]  len;
        logic [7:0]  sys;
        logic [7:0]  comp;
        logic [7:0]  pay;
        logic [7:0]  extra;
    } frame_item_t;

    // One output transaction: a stream byte and its end-of-frame flag.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_beat_t;

    // A row of the directed table. When hand_typed is set, the bytes of the
    // row are written out by hand and are what the output must show; the
    // predictor still runs on that row to keep its own state in step.
    typedef struct packed {
        frame_item_t       item;
        logic              hand_typed;
        logic [3:0]        n_typed;
        logic [0:9][7:0]   typed_bytes;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [23:0] message_id;
    logic [7:0]  declared_length;
    logic [7:0]  system_id;
    logic [7:0]  component_id;
    logic [7:0]  payload_byte;
    logic [7:0]  crc_seed_extra;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        frame_last;

    // Shadow copy of the framer state, advanced once per accepted transaction.
    logic [15:0] shadow_crc;
    logic [7:0]  shadow_seq;
    logic        shadow_open;
    logic [7:0]  shadow_pay_count;

    // Stream bytes that the block still owes, oldest first.
    stream_beat_t bytes_owed[$];
    stim_row_t    dir_rows[$];
    stream_beat_t owed_head;

    int  mismatch_count;
    // Input transactions accepted so far.
    int  sent_items;
    // Once set, neither side idles any more, so the tail of the run goes at full rate.
    bit  calm;

    mavlink2_frame_builder_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .message_id      (message_id),
        .declared_length (declared_length),
        .system_id       (system_id),
        .component_id    (component_id),
        .payload_byte    (payload_byte),
        .crc_seed_extra  (crc_seed_extra),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .frame_last      (frame_last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // CRC-16/X.25 in its bit-serial form: reflected polynomial 0x8408, one
    // shift per input bit, least significant bit first.
    function automatic logic [15:0] x25_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ 16'h8408;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // Works out the stream bytes caused by one accepted transaction and
    // advances the shadow state. Returns how many bytes were produced.
    function automatic int frame_bytes_for(input frame_item_t it, output stream_beat_t beats[10]);
        logic [0:9][7:0] hdr;
        int n;
        n = 0;
        case (it.mode)
            MODE_HDR:
            begin
                if (!shadow_open)
                begin
                    hdr = {STX_BYTE, it.len, 8'h00, 8'h00, shadow_seq, it.sys, it.comp,
                           it.mid[7:0], it.mid[15:8], it.mid[23:16]};
                    shadow_seq = shadow_seq + 8'd1;
                    // The start byte is not covered by the checksum.
                    shadow_crc = CRC_INIT;
                    for (int i = 1; i < 10; i++)
                        shadow_crc = x25_update(shadow_crc, hdr[i]);
                    for (int i = 0; i < 10; i++)
                        beats[i] = '{hdr[i], 1'b0};
                    shadow_open      = 1'b1;
                    shadow_pay_count = 8'd0;
                    n = 10;
                end
            end
            MODE_PAY:
            begin
                if (shadow_open && shadow_pay_count < MAX_PAYLOAD)
                begin
                    shadow_crc       = x25_update(shadow_crc, it.pay);
                    shadow_pay_count = shadow_pay_count + 8'd1;
                    beats[0] = '{it.pay, 1'b0};
                    n = 1;
                end
            end
            MODE_END:
            begin
                if (shadow_open)
                begin
                    shadow_crc = x25_update(shadow_crc, it.extra);
                    beats[0] = '{shadow_crc[7:0], 1'b0};
                    beats[1] = '{shadow_crc[15:8], 1'b1};
                    shadow_crc       = CRC_INIT;
                    shadow_pay_count = 8'd0;
                    shadow_open      = 1'b0;
                    n = 2;
                end
            end
            default:
            begin
            end
        endcase
        return n;
    endfunction

    function automatic frame_item_t random_item(input logic [1:0] md);
        frame_item_t it;
        it.mode  = md;
        it.mid   = 24'($urandom);
        it.len   = 8'($urandom);
        it.sys   = 8'($urandom);
        it.comp  = 8'($urandom);
        it.pay   = 8'($urandom);
        it.extra = 8'($urandom);
        return it;
    endfunction

    function automatic void add_row(input logic [1:0] md, input logic [23:0] mid,
                                    input logic [7:0] len, input logic [7:0] sys,
                                    input logic [7:0] comp, input logic [7:0] pay,
                                    input logic [7:0] extra, input bit typed, input int n,
                                    input logic [0:9][7:0] bytes);
        stim_row_t r;
        r.item        = '{md, mid, len, sys, comp, pay, extra};
        r.hand_typed  = typed;
        r.n_typed     = 4'(n);
        r.typed_bytes = bytes;
        dir_rows.push_back(r);
    endfunction

    // Presents one transaction, optionally after a random idle burst, and
    // waits for the handshake. At the accepting edge the expected bytes are
    // queued, either the hand-typed ones or the predicted ones.
    task automatic send_item(input frame_item_t it, input bit typed, input int n_typed,
                             input logic [0:9][7:0] typed_bytes);
        stream_beat_t beats[10];
        int n;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        mode            <= it.mode;
        message_id      <= it.mid;
        declared_length <= it.len;
        system_id       <= it.sys;
        component_id    <= it.comp;
        payload_byte    <= it.pay;
        crc_seed_extra  <= it.extra;
        do
            @(posedge clk);
        while (!in_ready);
        n = frame_bytes_for(it, beats);
        sent_items++;
        if (typed)
        begin
            for (int i = 0; i < n_typed; i++)
                bytes_owed.push_back('{typed_bytes[i], 1'b0});
        end
        else
        begin
            for (int i = 0; i < n; i++)
                bytes_owed.push_back(beats[i]);
        end
    endtask

    // Sends one well-formed frame: a header, n_pay payload bytes and an end.
    // With noisy set, one stray transaction is slipped in among the payload.
    task automatic send_frame(input int n_pay, input bit noisy);
        int noise_at;
        noise_at = noisy ? $urandom_range(0, n_pay) : -1;
        send_item(random_item(MODE_HDR), 1'b0, 0, '0);
        for (int i = 0; i <= n_pay; i++)
        begin
            if (i == noise_at)
                send_item(random_item($urandom_range(0, 1) ? MODE_HDR : MODE_NONE),
                          1'b0, 0, '0);
            if (i < n_pay)
                send_item(random_item(MODE_PAY), 1'b0, 0, '0);
        end
        send_item(random_item(MODE_END), 1'b0, 0, '0);
    endtask

    // Output side: every transaction that the block hands over is compared
    // with the oldest byte still owed, field by field.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (bytes_owed.size() == 0)
            begin
                $display("%0t: unexpected output: expected none, actual byte %02h last %0b",
                         $time, out_byte, frame_last);
                mismatch_count++;
            end
            else
            begin
                owed_head = bytes_owed.pop_front();
                if (out_byte !== owed_head.data)
                begin
                    $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                             $time, owed_head.data, out_byte);
                    mismatch_count++;
                end
                if (frame_last !== owed_head.last)
                begin
                    $display("%0t: frame_last mismatch: expected %0b, actual %0b",
                             $time, owed_head.last, frame_last);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver back-pressure: random stall bursts between runs of readiness, and none at all
    // once the run has calmed down.
    initial
    begin
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    // Watchdog. The slowest legal run ends well before this timeout, so this
    // only fires if the block hangs.
    initial
    begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        mismatch_count   = 0;
        sent_items       = 0;
        calm             = 1'b0;
        shadow_crc       = CRC_INIT;
        shadow_seq       = 8'd0;
        shadow_open      = 1'b0;
        shadow_pay_count = 8'd0;

        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        mode            <= MODE_NONE;
        message_id      <= '0;
        declared_length <= '0;
        system_id       <= '0;
        component_id    <= '0;
        payload_byte    <= '0;
        crc_seed_extra  <= '0;

        // Directed table. Ignored transactions and the two headers whose bytes
        // are plain to see are typed in; the rest rely on the predictor.
        // Nothing is open after reset, so payload, end and the unused mode are ignored.
        add_row(MODE_PAY,  24'h000000, 8'h00, 8'h00, 8'h00, 8'h5A, 8'h00, 1'b1, 0, '0);
        add_row(MODE_END,  24'h000000, 8'h00, 8'h00, 8'h00, 8'h00, 8'hA5, 1'b1, 0, '0);
        add_row(MODE_NONE, 24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 0, '0);
        // First header after reset carries sequence zero; all fields at their maximum.
        add_row(MODE_HDR,  24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1, 10,
                {8'hFD, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        // A second header while the frame is open is dropped.
        add_row(MODE_HDR,  24'h000000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 0, '0);
        add_row(MODE_PAY,  24'h000000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 0, '0);
        add_row(MODE_PAY,  24'h000000, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0, 0, '0);
        add_row(MODE_NONE, 24'h000000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 0, '0);
        add_row(MODE_END,  24'h000000, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 0, '0);
        // Second header: sequence one, all fields at zero.
        add_row(MODE_HDR,  24'h000000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 10,
                {8'hFD, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        // Frame with no payload at all.
        add_row(MODE_END,  24'h000000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 0, '0);
        add_row(MODE_HDR,  24'h123456, 8'h03, 8'h01, 8'hBE, 8'h00, 8'h00, 1'b0, 0, '0);
        add_row(MODE_PAY,  24'h000000, 8'h00, 8'h00, 8'h00, 8'hA5, 8'h00, 1'b0, 0, '0);
        add_row(MODE_PAY,  24'h000000, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 1'b0, 0, '0);
        add_row(MODE_END,  24'h000000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5A, 1'b0, 0, '0);
        // Closed again, so a stray end is ignored.
        add_row(MODE_END,  24'h000000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 0, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].hand_typed, dir_rows[i].n_typed,
                      dir_rows[i].typed_bytes);

        // Random part: mostly well-formed frames with random content and
        // small payloads, a few longer ones, some with a stray transaction
        // inside, and some loose noise between frames.
        while (sent_items < 110)
        begin
            if (sent_items >= 85)
                calm = 1'b1;
            if ($urandom_range(0, 9) == 0)
                send_item(random_item(2'($urandom_range(0, 3))), 1'b0, 0, '0);
            else
                send_frame(($urandom_range(0, 4) == 0) ? $urandom_range(0, 20)
                                                        : $urandom_range(0, 8),
                           $urandom_range(0, 7) == 0);
        end

        // Drain: the stimulus is done, wait for every owed byte and then a
        // little longer in case the block emits something extra.
        in_valid <= 1'b0;
        while (bytes_owed.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/mv2fb_pkg.sv
sv/mv2fb_front.sv
sv/mv2fb_fifo.sv
sv/mv2fb_back.sv
sv/mavlink2_frame_builder_top.sv
tb/sv/tb.sv
